// File: design/fgpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy-gain PI controller: shared definitions
// Widths, reset values, rule tables, controller command and state types, and
// the saturation, clamp and membership functions used by the datapath.
// ----------------------------------------------------------------------------
package fgpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SCALE_W   = DATA_W - 1;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SP_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SP_W + 1;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int WPR_W     = 2 * FRAC_BITS + 1;
    localparam int RULE_W    = 4;
    localparam int ACC_W     = 2 * FRAC_BITS + 4;
    localparam int QT_W      = FRAC_BITS + 4;
    localparam int SEG_W     = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [WGT_W-1:0]         ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SP_W-1:0]   Q_MAX    = SP_W'(6) <<< FRAC_BITS;
    localparam logic signed [SP_W-1:0]   Q_MIN    = -Q_MAX;
    localparam logic [QT_W-1:0]          Q_OFS    = QT_W'(6) << FRAC_BITS;
    localparam logic [SEG_W-1:0]         SEG_LAST = SEG_W'(5);
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic signed [DATA_W-1:0] UNITY_RST     = DATA_W'(ONE);
    localparam logic [SCALE_W-1:0]       ERR_SCALE_RST = SCALE_W'(ONE);
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST   = DATA_W'(100) <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST   = -OUT_MAX_RST;

    localparam int RULE_KP [7][7] = '{
        '{ 6,  6,  4,  4,  2,  0,  0},
        '{ 6,  6,  4,  2,  2,  0,  0},
        '{ 4,  4,  4,  2,  0, -2, -2},
        '{ 4,  4,  2,  0, -2, -4, -4},
        '{ 2,  2,  0, -2, -2, -4, -4},
        '{ 2,  0, -2, -4, -4, -4, -6},
        '{ 0,  0, -4, -4, -4, -6, -6}};

    localparam int RULE_KI [7][7] = '{
        '{-6, -6, -4, -4, -2,  0,  0},
        '{-6, -6, -4, -2, -2,  0,  0},
        '{-6, -4, -2, -2,  0,  2,  2},
        '{-4, -4, -2,  0,  2,  4,  4},
        '{-4, -2,  0,  2,  2,  4,  6},
        '{ 0,  0,  2,  2,  4,  6,  6},
        '{ 0,  0,  2,  4,  4,  6,  6}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_BASE,
        REG_KI_BASE,
        REG_ERROR_SCALE,
        REG_KP_ADJUST_SCALE,
        REG_KI_ADJUST_SCALE,
        REG_OUT_MIN,
        REG_OUT_MAX,
        REG_FEEDFORWARD_GAIN
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_QE,
        MUL_QEC,
        MUL_WGT,
        MUL_FF,
        MUL_AP,
        MUL_AI,
        MUL_KP,
        MUL_KI
    } mul_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_LOAD,
        WB_DIFF,
        WB_QE,
        WB_QEC,
        WB_WGT,
        WB_FF,
        WB_KP,
        WB_KI,
        WB_PTERM,
        WB_INT,
        WB_DRIVE,
        WB_OUT
    } wb_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_QE,
        ST_QEC,
        ST_W00,
        ST_W01,
        ST_W10,
        ST_W11,
        ST_WLAST,
        ST_ADJ_P,
        ST_ADJ_I,
        ST_KP,
        ST_KI,
        ST_INT,
        ST_DRIVE,
        ST_OUT
    } state_t;

    typedef struct packed {
        wb_op_t  wb;
        mul_op_t mul;
        logic    sel_i;
        logic    sel_j;
    } dp_cmd_t;

    typedef struct packed {
        logic             ok;
        logic [SEG_W-1:0] seg;
        logic [WGT_W-1:0] w_lo;
        logic [WGT_W-1:0] w_hi;
    } memb_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        if (x > SUM_W'(DATA_MAX)) begin
            return DATA_MAX;
        end else if (x < SUM_W'(DATA_MIN)) begin
            return DATA_MIN;
        end
        return DATA_W'(x);
    endfunction

    // The lower limit is tested first, so inverted limits favour the lower one.
    function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [SUM_W-1:0] x,
                                                         input logic signed [DATA_W-1:0] lo,
                                                         input logic signed [DATA_W-1:0] hi);
        if (x < SUM_W'(lo)) begin
            return lo;
        end else if (x > SUM_W'(hi)) begin
            return hi;
        end
        return DATA_W'(x);
    endfunction

    // Segment and triangular weights of a quantised value; the top segment
    // also takes the upper end of the universe.
    function automatic memb_t memb(input logic signed [SP_W-1:0] q);
        memb_t            r;
        logic [QT_W-1:0]  t;
        r.ok = (q >= Q_MIN) && (q <= Q_MAX);
        t = q[QT_W-1:0] + Q_OFS;
        if (t[QT_W-1:FRAC_BITS+1] > SEG_LAST) begin
            r.seg  = SEG_LAST;
            r.w_hi = ONE;
        end else begin
            r.seg  = t[QT_W-1:FRAC_BITS+1];
            r.w_hi = {1'b0, t[FRAC_BITS:1]};
        end
        r.w_lo = ONE - r.w_hi;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/fgpi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy-gain PI controller: sequencer
// Steps each sample through the datapath, issuing at most one multiplier operation and
// at most one write-back per cycle, and owns the result valid flag.
// ----------------------------------------------------------------------------
module fgpi_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fgpi_pkg::dp_cmd_t      cmd
);
    import fgpi_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.wb       = WB_NONE;
        cmd.mul      = MUL_NONE;
        cmd.sel_i    = 1'b0;
        cmd.sel_j    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.wb     = WB_LOAD;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.wb     = WB_DIFF;
                cmd.mul    = MUL_QE;
                state_next = ST_QE;
            end
            ST_QE: begin
                cmd.wb     = WB_QE;
                cmd.mul    = MUL_QEC;
                state_next = ST_QEC;
            end
            ST_QEC: begin
                cmd.wb     = WB_QEC;
                state_next = ST_W00;
            end
            ST_W00: begin
                cmd.mul    = MUL_WGT;
                state_next = ST_W01;
            end
            ST_W01: begin
                cmd.wb     = WB_WGT;
                cmd.mul    = MUL_WGT;
                cmd.sel_j  = 1'b1;
                state_next = ST_W10;
            end
            ST_W10: begin
                cmd.wb     = WB_WGT;
                cmd.mul    = MUL_WGT;
                cmd.sel_i  = 1'b1;
                state_next = ST_W11;
            end
            ST_W11: begin
                cmd.wb     = WB_WGT;
                cmd.mul    = MUL_WGT;
                cmd.sel_i  = 1'b1;
                cmd.sel_j  = 1'b1;
                state_next = ST_WLAST;
            end
            ST_WLAST: begin
                cmd.wb     = WB_WGT;
                cmd.mul    = MUL_FF;
                state_next = ST_ADJ_P;
            end
            ST_ADJ_P: begin
                cmd.wb     = WB_FF;
                cmd.mul    = MUL_AP;
                state_next = ST_ADJ_I;
            end
            ST_ADJ_I: begin
                cmd.wb     = WB_KP;
                cmd.mul    = MUL_AI;
                state_next = ST_KP;
            end
            ST_KP: begin
                cmd.wb     = WB_KI;
                cmd.mul    = MUL_KP;
                state_next = ST_KI;
            end
            ST_KI: begin
                cmd.wb     = WB_PTERM;
                cmd.mul    = MUL_KI;
                state_next = ST_INT;
            end
            ST_INT: begin
                cmd.wb     = WB_INT;
                state_next = ST_DRIVE;
            end
            ST_DRIVE: begin
                cmd.wb     = WB_DRIVE;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.wb       = WB_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    // A waiting result is never overwritten before it has been transferred.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb == WB_OUT) |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a result was pending");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result valid raised outside the output step");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIFF && !s_ready))
        else $error("sequencer did not start after an input transfer");

endmodule
`default_nettype wire

// File: design/fgpi_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy-gain PI controller: datapath
// Configuration registers, controller state, one shared signed multiplier with
// a registered product, fuzzy weighting and the output register.
// ----------------------------------------------------------------------------
module fgpi_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire fgpi_pkg::dp_cmd_t                     cmd,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fgpi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fgpi_pkg::DATA_W-1:0]           cfg_data,
    input  wire logic signed [fgpi_pkg::DATA_W-1:0]    s_measurement,
    input  wire logic signed [fgpi_pkg::DATA_W-1:0]    s_target,
    input  wire logic                                  s_add_feedforward,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_drive,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_error_now,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_kp_now,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_ki_now
);
    import fgpi_pkg::*;

    // Configuration
    logic signed [DATA_W-1:0] kp_base_reg;
    logic signed [DATA_W-1:0] ki_base_reg;
    logic [SCALE_W-1:0]       error_scale_reg;
    logic signed [DATA_W-1:0] kp_adj_reg;
    logic signed [DATA_W-1:0] ki_adj_reg;
    logic signed [DATA_W-1:0] out_min_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic signed [DATA_W-1:0] ff_gain_reg;

    // Controller state
    logic signed [DATA_W-1:0] prev_err_reg;
    logic signed [DATA_W-1:0] prev_err_next;
    logic signed [DATA_W-1:0] prev_tgt_reg;
    logic signed [DATA_W-1:0] prev_tgt_next;
    logic signed [DATA_W-1:0] integral_reg;
    logic signed [DATA_W-1:0] integral_next;

    // Working registers
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] err_next;
    logic signed [MUL_W-1:0]  dtgt_reg;
    logic signed [MUL_W-1:0]  dtgt_next;
    logic signed [MUL_W-1:0]  derr_reg;
    logic signed [MUL_W-1:0]  derr_next;
    logic                     ff_en_reg;
    logic                     ff_en_next;
    logic                     qe_ok_reg;
    logic                     qe_ok_next;
    logic                     q_ok_reg;
    logic                     q_ok_next;
    logic [SEG_W-1:0]         ke_reg;
    logic [SEG_W-1:0]         ke_next;
    logic [SEG_W-1:0]         kc_reg;
    logic [SEG_W-1:0]         kc_next;
    logic [WGT_W-1:0]         we_lo_reg;
    logic [WGT_W-1:0]         we_lo_next;
    logic [WGT_W-1:0]         we_hi_reg;
    logic [WGT_W-1:0]         we_hi_next;
    logic [WGT_W-1:0]         wc_lo_reg;
    logic [WGT_W-1:0]         wc_lo_next;
    logic [WGT_W-1:0]         wc_hi_reg;
    logic [WGT_W-1:0]         wc_hi_next;
    logic signed [ACC_W-1:0]  acc_p_reg;
    logic signed [ACC_W-1:0]  acc_p_next;
    logic signed [ACC_W-1:0]  acc_i_reg;
    logic signed [ACC_W-1:0]  acc_i_next;
    logic signed [SP_W-1:0]   ff_term_reg;
    logic signed [SP_W-1:0]   ff_term_next;
    logic signed [DATA_W-1:0] kp_reg;
    logic signed [DATA_W-1:0] kp_next;
    logic signed [DATA_W-1:0] ki_reg;
    logic signed [DATA_W-1:0] ki_next;
    logic signed [SP_W-1:0]   pterm_reg;
    logic signed [SP_W-1:0]   pterm_next;
    logic signed [DATA_W-1:0] drive_reg;
    logic signed [DATA_W-1:0] drive_next;

    // Shared multiplier
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_i_reg;
    logic                     prod_j_reg;
    logic signed [SP_W-1:0]   sp;
    logic signed [SP_W-2:0]   spq;
    logic signed [SP_W-1:0]   adj;

    // Fuzzy weighting
    memb_t                           memb_res;
    logic [SEG_W-1:0]                rule_row;
    logic [SEG_W-1:0]                rule_col;
    logic signed [RULE_W-1:0]        rule_p;
    logic signed [RULE_W-1:0]        rule_i;
    logic signed [WPR_W:0]           wgt;
    logic signed [WPR_W+RULE_W:0]    term_p;
    logic signed [WPR_W+RULE_W:0]    term_i;

    // Output register
    logic signed [DATA_W-1:0] m_drive_reg;
    logic signed [DATA_W-1:0] m_drive_next;
    logic signed [DATA_W-1:0] m_error_now_reg;
    logic signed [DATA_W-1:0] m_kp_now_reg;
    logic signed [DATA_W-1:0] m_ki_now_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_base_reg     <= UNITY_RST;
            ki_base_reg     <= '0;
            error_scale_reg <= ERR_SCALE_RST;
            kp_adj_reg      <= '0;
            ki_adj_reg      <= '0;
            out_min_reg     <= OUT_MIN_RST;
            out_max_reg     <= OUT_MAX_RST;
            ff_gain_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_KP_BASE:          kp_base_reg     <= cfg_data;
                REG_KI_BASE:          ki_base_reg     <= cfg_data;
                REG_ERROR_SCALE:      error_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_KP_ADJUST_SCALE:  kp_adj_reg      <= cfg_data;
                REG_KI_ADJUST_SCALE:  ki_adj_reg      <= cfg_data;
                REG_OUT_MIN:          out_min_reg     <= cfg_data;
                REG_OUT_MAX:          out_max_reg     <= cfg_data;
                REG_FEEDFORWARD_GAIN: ff_gain_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_QE: begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({2'b00, error_scale_reg});
            end
            MUL_QEC: begin
                mul_a = derr_reg;
                mul_b = $signed({2'b00, error_scale_reg});
            end
            MUL_WGT: begin
                mul_a = $signed({{(MUL_W-WGT_W){1'b0}}, cmd.sel_i ? we_hi_reg : we_lo_reg});
                mul_b = $signed({{(MUL_W-WGT_W){1'b0}}, cmd.sel_j ? wc_hi_reg : wc_lo_reg});
            end
            MUL_FF: begin
                mul_a = dtgt_reg;
                mul_b = MUL_W'(ff_gain_reg);
            end
            MUL_AP: begin
                mul_a = MUL_W'($signed(acc_p_reg[ACC_W-1:FRAC_BITS]));
                mul_b = MUL_W'(kp_adj_reg);
            end
            MUL_AI: begin
                mul_a = MUL_W'($signed(acc_i_reg[ACC_W-1:FRAC_BITS]));
                mul_b = MUL_W'(ki_adj_reg);
            end
            MUL_KP: begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(kp_reg);
            end
            MUL_KI: begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(ki_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sp       = $signed(prod_reg[PROD_W-1:FRAC_BITS]);
    assign spq      = $signed(prod_reg[PROD_W-1:FRAC_BITS+1]);
    assign adj      = q_ok_reg ? sp : '0;
    assign memb_res = memb((cmd.wb == WB_QE) ? sp : SP_W'(spq));

    assign rule_row = ke_reg + {{(SEG_W-1){1'b0}}, prod_i_reg};
    assign rule_col = kc_reg + {{(SEG_W-1){1'b0}}, prod_j_reg};
    assign rule_p   = RULE_W'(RULE_KP[rule_row][rule_col]);
    assign rule_i   = RULE_W'(RULE_KI[rule_row][rule_col]);
    assign wgt      = $signed({1'b0, prod_reg[WPR_W-1:0]});
    assign term_p   = wgt * rule_p;
    assign term_i   = wgt * rule_i;

    always_comb begin
        prev_err_next = prev_err_reg;
        prev_tgt_next = prev_tgt_reg;
        integral_next = integral_reg;
        err_next      = err_reg;
        dtgt_next     = dtgt_reg;
        derr_next     = derr_reg;
        ff_en_next    = ff_en_reg;
        qe_ok_next    = qe_ok_reg;
        q_ok_next     = q_ok_reg;
        ke_next       = ke_reg;
        kc_next       = kc_reg;
        we_lo_next    = we_lo_reg;
        we_hi_next    = we_hi_reg;
        wc_lo_next    = wc_lo_reg;
        wc_hi_next    = wc_hi_reg;
        acc_p_next    = acc_p_reg;
        acc_i_next    = acc_i_reg;
        ff_term_next  = ff_term_reg;
        kp_next       = kp_reg;
        ki_next       = ki_reg;
        pterm_next    = pterm_reg;
        drive_next    = drive_reg;
        m_drive_next  = m_drive_reg;
        case (cmd.wb)
            WB_LOAD: begin
                err_next      = sat32(SUM_W'(s_target) - SUM_W'(s_measurement));
                dtgt_next     = MUL_W'(s_target) - MUL_W'(prev_tgt_reg);
                prev_tgt_next = s_target;
                ff_en_next    = s_add_feedforward;
            end
            WB_DIFF: begin
                derr_next     = MUL_W'(err_reg) - MUL_W'(prev_err_reg);
                prev_err_next = err_reg;
            end
            WB_QE: begin
                qe_ok_next = memb_res.ok;
                ke_next    = memb_res.seg;
                we_lo_next = memb_res.w_lo;
                we_hi_next = memb_res.w_hi;
            end
            WB_QEC: begin
                q_ok_next  = qe_ok_reg && memb_res.ok;
                kc_next    = memb_res.seg;
                wc_lo_next = memb_res.w_lo;
                wc_hi_next = memb_res.w_hi;
                acc_p_next = '0;
                acc_i_next = '0;
            end
            WB_WGT: begin
                acc_p_next = acc_p_reg + ACC_W'(term_p);
                acc_i_next = acc_i_reg + ACC_W'(term_i);
            end
            WB_FF: begin
                ff_term_next = sp;
            end
            WB_KP: begin
                kp_next = sat32(SUM_W'(kp_base_reg) + SUM_W'(adj));
            end
            WB_KI: begin
                ki_next = sat32(SUM_W'(ki_base_reg) + SUM_W'(adj));
            end
            WB_PTERM: begin
                pterm_next = sp;
            end
            WB_INT: begin
                integral_next = clamp32(SUM_W'(integral_reg) + SUM_W'(sp),
                                        out_min_reg >>> 1, out_max_reg >>> 1);
            end
            WB_DRIVE: begin
                drive_next = clamp32(SUM_W'(pterm_reg) + SUM_W'(integral_reg),
                                     out_min_reg, out_max_reg);
            end
            WB_OUT: begin
                if (ff_en_reg) begin
                    m_drive_next = clamp32(SUM_W'(drive_reg) + SUM_W'(ff_term_reg),
                                           out_min_reg, out_max_reg);
                end else begin
                    m_drive_next = drive_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            prev_tgt_reg <= '0;
            integral_reg <= '0;
        end else begin
            prev_err_reg <= prev_err_next;
            prev_tgt_reg <= prev_tgt_next;
            integral_reg <= integral_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= mul_a * mul_b;
        prod_i_reg  <= cmd.sel_i;
        prod_j_reg  <= cmd.sel_j;
        err_reg     <= err_next;
        dtgt_reg    <= dtgt_next;
        derr_reg    <= derr_next;
        ff_en_reg   <= ff_en_next;
        qe_ok_reg   <= qe_ok_next;
        q_ok_reg    <= q_ok_next;
        ke_reg      <= ke_next;
        kc_reg      <= kc_next;
        we_lo_reg   <= we_lo_next;
        we_hi_reg   <= we_hi_next;
        wc_lo_reg   <= wc_lo_next;
        wc_hi_reg   <= wc_hi_next;
        acc_p_reg   <= acc_p_next;
        acc_i_reg   <= acc_i_next;
        ff_term_reg <= ff_term_next;
        kp_reg      <= kp_next;
        ki_reg      <= ki_next;
        pterm_reg   <= pterm_next;
        drive_reg   <= drive_next;
        m_drive_reg <= m_drive_next;
        if (cmd.wb == WB_OUT) begin
            m_error_now_reg <= err_reg;
            m_kp_now_reg    <= kp_reg;
            m_ki_now_reg    <= ki_reg;
        end
    end

    assign m_drive     = m_drive_reg;
    assign m_error_now = m_error_now_reg;
    assign m_kp_now    = m_kp_now_reg;
    assign m_ki_now    = m_ki_now_reg;

    a_integral_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb == WB_INT && out_min_reg <= out_max_reg) |=>
        (integral_reg >= ($past(out_min_reg) >>> 1)) &&
        (integral_reg <= ($past(out_max_reg) >>> 1)))
        else $error("integral sum left the half-limit band");

    a_drive_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb == WB_OUT && out_min_reg <= out_max_reg) |=>
        (m_drive_reg >= $past(out_min_reg)) && (m_drive_reg <= $past(out_max_reg)))
        else $error("drive outside the configured limits");

endmodule
`default_nettype wire

// File: design/fuzzy_gain_pi_controller.sv
// A new sample is accepted only from the idle state, once the previous sample
// has made all eleven passes through the single shared 33x33 multiplier and
// its result has been loaded into the output register.
// A finished result waits in the output register while the next sample runs.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the previous error, the previous setpoint and the integral sum.
`default_nettype none
// ----------------------------------------------------------------------------
// Fuzzy-gain PI controller
// Top level: joins the sequencer and the datapath, and exposes the sample,
// result and configuration channels.
// ----------------------------------------------------------------------------
module fuzzy_gain_pi_controller (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [fgpi_pkg::DATA_W-1:0]    s_measurement,
    input  wire logic signed [fgpi_pkg::DATA_W-1:0]    s_target,
    input  wire logic                                  s_add_feedforward,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_drive,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_error_now,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_kp_now,
    output logic signed [fgpi_pkg::DATA_W-1:0]         m_ki_now,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fgpi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fgpi_pkg::DATA_W-1:0]           cfg_data
);
    import fgpi_pkg::*;

    dp_cmd_t cmd;

    fgpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fgpi_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_measurement     (s_measurement),
        .s_target          (s_target),
        .s_add_feedforward (s_add_feedforward),
        .m_drive           (m_drive),
        .m_error_now       (m_error_now),
        .m_kp_now          (m_kp_now),
        .m_ki_now          (m_ki_now)
    );

endmodule
`default_nettype wire
